FILE: hdl/tccs_pkg.sv
package tccs_pkg;

	localparam int MAX_W      = 32;
	localparam int MAX_H      = 32;
	localparam int TILES      = 5;
	localparam int CELLS      = MAX_W * MAX_H;
	localparam int ADDR_W     = $clog2(CELLS);
	localparam int X_W        = $clog2(MAX_W);
	localparam int Y_W        = $clog2(MAX_H);
	localparam int SIZE_W     = 6;
	localparam int CNT_W      = $clog2(CELLS + 1);
	localparam int POP_W      = $clog2(TILES + 2);
	localparam int PICK_W     = 16;
	localparam int RULE_W     = TILES * TILES;
	localparam int STATUS_W   = 2;
	localparam int TILE_W     = 3;
	localparam int CFG_IDX_W  = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EAST   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SOUTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WEST   = 3'd5;

	// neighbor directions
	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CONFL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd2;

	localparam logic [TILES-1:0] ALL_TILES = {TILES{1'b1}};

	typedef struct packed {
		logic [TILES-1:0] mask;
		logic             coll;
		logic             pend;
	} cell_t;

	localparam cell_t CELL_RESET = '{mask: ALL_TILES, coll: 1'b0, pend: 1'b0};

	function automatic logic [POP_W-1:0] popcnt(input logic [TILES-1:0] m);
		logic [POP_W-1:0] n;
		n = '0;
		for (int t = 0; t < TILES; t++) begin
			n = n + POP_W'(m[t]);
		end
		return n;
	endfunction

	// union of the rule masks of every tile set in m
	function automatic logic [TILES-1:0] allowed(input logic [RULE_W-1:0] r,
			input logic [TILES-1:0] m);
		logic [TILES-1:0] acc;
		acc = '0;
		for (int t = 0; t < TILES; t++) begin
			if (m[t]) begin
				acc = acc | r[t*TILES +: TILES];
			end
		end
		return acc;
	endfunction

	// index of the k-th set bit of m, counting from the lowest
	function automatic logic [TILE_W-1:0] kth_tile(input logic [TILES-1:0] m,
			input logic [POP_W-1:0] k);
		logic [POP_W-1:0] seen;
		logic [TILE_W-1:0] res;
		logic found;
		seen = '0;
		res = '0;
		found = 1'b0;
		for (int t = 0; t < TILES; t++) begin
			if (m[t] && !found) begin
				if (seen == k) begin
					res = TILE_W'(t);
					found = 1'b1;
				end
				seen = seen + 1'b1;
			end
		end
		return res;
	endfunction

	// size register clamped to 1..max
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] mx);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > mx) begin
			r = mx;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [X_W-1:0] x,
			input logic [Y_W-1:0] y);
		return ADDR_W'(ADDR_W'(y) * MAX_W) + ADDR_W'(x);
	endfunction

endpackage

FILE: hdl/tccs_mem.sv
module tccs_mem (
	input  logic                          clk,
	input  logic                          we,
	input  logic [tccs_pkg::ADDR_W-1:0]   waddr,
	input  tccs_pkg::cell_t               wdata,
	input  logic [tccs_pkg::ADDR_W-1:0]   raddr,
	output tccs_pkg::cell_t               rdata
);

	tccs_pkg::cell_t mem_q [tccs_pkg::CELLS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/tccs_div.sv
module tccs_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tccs_pkg::PICK_W-1:0]  dividend,
	input  logic [tccs_pkg::CNT_W-1:0]   divisor,
	output logic                         done,
	output logic [tccs_pkg::CNT_W-1:0]   rem
);

	localparam int STEP_W = $clog2(tccs_pkg::PICK_W + 1);

	logic [tccs_pkg::PICK_W-1:0] dvd_q;
	logic [tccs_pkg::CNT_W-1:0]  dsr_q;
	logic [tccs_pkg::CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0]           cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [tccs_pkg::CNT_W:0]    trial;

	// one restoring step per cycle
	assign trial = {rem_q, dvd_q[tccs_pkg::PICK_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= STEP_W'(tccs_pkg::PICK_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[tccs_pkg::PICK_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= tccs_pkg::CNT_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= tccs_pkg::CNT_W'(trial);
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: hdl/tile_constraint_collapse_step.sv
// Tile constraint collapse step over a grid of up to 32 x 32 cells.
// Request channel (req_valid/req_stall) carries cell_pick and tile_pick; each
// request transaction yields exactly one response transaction on the
// rsp_valid/rsp_stall channel with status, cell_x, cell_y and tile.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// One request is worked at a time: req_stall is low only in the idle state.
// Steps per request, w x h the area in use:
//   minimum scan over the w x h cells, divider, chooser scan up to the chosen cell,
//   tile choice, then propagation passes over the cells with a neighbor check
//   per direction for each worklist cell, then the output register.
// A complete grid or a contradiction adds a clearing sweep over all 1024 cells.
// The cell state lives in one 1024 x 7 memory with a registered read, so
// every cell visit takes a read state and an evaluate state; that memory port
// sets the rate.
// After reset the block sweeps all 1024 memory cells, holding req_stall.
// The result sits in an output register; a stalled response holds, and the
// block can take the next request meanwhile, finishing it only once the
// output register is free.
module tile_constraint_collapse_step (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tccs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tccs_pkg::RULE_W-1:0]       cfg_data,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [tccs_pkg::PICK_W-1:0]       cell_pick,
	input  logic [tccs_pkg::PICK_W-1:0]       tile_pick,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [tccs_pkg::STATUS_W-1:0]     status,
	output logic [tccs_pkg::X_W-1:0]          cell_x,
	output logic [tccs_pkg::Y_W-1:0]          cell_y,
	output logic [tccs_pkg::TILE_W-1:0]       tile
);

	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_S1_RD  = 5'd2;
	localparam logic [4:0] S_S1_EV  = 5'd3;
	localparam logic [4:0] S_S1_END = 5'd4;
	localparam logic [4:0] S_DIV1   = 5'd5;
	localparam logic [4:0] S_S2_RD  = 5'd6;
	localparam logic [4:0] S_S2_EV  = 5'd7;
	localparam logic [4:0] S_PK_RD  = 5'd8;
	localparam logic [4:0] S_PK_EV  = 5'd9;
	localparam logic [4:0] S_DIV2   = 5'd10;
	localparam logic [4:0] S_PK_WR  = 5'd11;
	localparam logic [4:0] S_P_RD   = 5'd12;
	localparam logic [4:0] S_P_EV   = 5'd13;
	localparam logic [4:0] S_N_CHK  = 5'd14;
	localparam logic [4:0] S_N_EV   = 5'd15;
	localparam logic [4:0] S_FIN    = 5'd16;

	localparam logic [tccs_pkg::SIZE_W-1:0] MAXW = tccs_pkg::SIZE_W'(tccs_pkg::MAX_W);
	localparam logic [tccs_pkg::SIZE_W-1:0] MAXH = tccs_pkg::SIZE_W'(tccs_pkg::MAX_H);

	logic [4:0]                        state_q;
	logic [tccs_pkg::ADDR_W-1:0]       clr_addr_q;
	logic                              clr_out_q;
	logic [tccs_pkg::SIZE_W-1:0]       width_q;
	logic [tccs_pkg::SIZE_W-1:0]       height_q;
	logic [tccs_pkg::RULE_W-1:0]       rules_q [4];
	logic [tccs_pkg::PICK_W-1:0]       cpick_q;
	logic [tccs_pkg::PICK_W-1:0]       tpick_q;
	logic [tccs_pkg::POP_W-1:0]        best_q;
	logic [tccs_pkg::CNT_W-1:0]        count_q;
	logic [tccs_pkg::CNT_W-1:0]        seen_q;
	logic [tccs_pkg::CNT_W-1:0]        target_q;
	logic [tccs_pkg::X_W-1:0]          x_q;
	logic [tccs_pkg::Y_W-1:0]          y_q;
	logic [tccs_pkg::X_W-1:0]          cx_q;
	logic [tccs_pkg::Y_W-1:0]          cy_q;
	logic [tccs_pkg::TILE_W-1:0]       tile_q;
	logic [tccs_pkg::STATUS_W-1:0]     status_q;
	logic [tccs_pkg::TILES-1:0]        cmask_q;
	logic [1:0]                        dir_q;
	logic                              again_q;
	logic                              rsp_valid_q;
	logic [tccs_pkg::STATUS_W-1:0]     rsp_status_q;
	logic [tccs_pkg::X_W-1:0]          rsp_x_q;
	logic [tccs_pkg::Y_W-1:0]          rsp_y_q;
	logic [tccs_pkg::TILE_W-1:0]       rsp_tile_q;

	logic [tccs_pkg::SIZE_W-1:0]       w_eff;
	logic [tccs_pkg::SIZE_W-1:0]       h_eff;
	logic                              last_cell;
	logic [tccs_pkg::X_W-1:0]          x_nxt;
	logic [tccs_pkg::Y_W-1:0]          y_nxt;
	logic                              n_ok;
	logic [tccs_pkg::X_W-1:0]          nx;
	logic [tccs_pkg::Y_W-1:0]          ny;
	logic [tccs_pkg::TILES-1:0]        nm;
	logic [tccs_pkg::POP_W-1:0]        rd_pop;
	logic                              out_free;

	logic                              mem_we;
	logic [tccs_pkg::ADDR_W-1:0]       mem_waddr;
	tccs_pkg::cell_t                   mem_wdata;
	logic [tccs_pkg::ADDR_W-1:0]       mem_raddr;
	tccs_pkg::cell_t                   rd;

	logic                              div_start;
	logic [tccs_pkg::PICK_W-1:0]       div_dvd;
	logic [tccs_pkg::CNT_W-1:0]        div_dsr;
	logic                              div_done;
	logic [tccs_pkg::CNT_W-1:0]        div_rem;

	tccs_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd)
	);

	tccs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.rem      (div_rem)
	);

	// effective area and raster stepping
	assign w_eff     = tccs_pkg::eff_size(width_q, MAXW);
	assign h_eff     = tccs_pkg::eff_size(height_q, MAXH);
	assign last_cell = ({1'b0, x_q} == w_eff - 1'b1) && ({1'b0, y_q} == h_eff - 1'b1);
	assign x_nxt     = ({1'b0, x_q} == w_eff - 1'b1) ? '0 : x_q + 1'b1;
	assign y_nxt     = ({1'b0, x_q} == w_eff - 1'b1) ? y_q + 1'b1 : y_q;
	assign rd_pop    = tccs_pkg::popcnt(rd.mask);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// neighbor in direction dir_q
	always_comb begin
		nx   = x_q;
		ny   = y_q;
		n_ok = 1'b0;
		case (dir_q)
			tccs_pkg::DIR_N: begin
				ny   = y_q - 1'b1;
				n_ok = (y_q != '0);
			end
			tccs_pkg::DIR_E: begin
				nx   = x_q + 1'b1;
				n_ok = ({1'b0, x_q} + 1'b1 < w_eff);
			end
			tccs_pkg::DIR_S: begin
				ny   = y_q + 1'b1;
				n_ok = ({1'b0, y_q} + 1'b1 < h_eff);
			end
			tccs_pkg::DIR_W: begin
				nx   = x_q - 1'b1;
				n_ok = (x_q != '0);
			end
			default: begin
				n_ok = 1'b0;
			end
		endcase
	end

	assign nm = rd.mask & tccs_pkg::allowed(rules_q[dir_q], cmask_q);

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tccs_pkg::cell_addr(x_q, y_q);
		mem_wdata = tccs_pkg::CELL_RESET;
		mem_raddr = tccs_pkg::cell_addr(x_q, y_q);
		case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
			end
			S_PK_RD: begin
				mem_raddr = tccs_pkg::cell_addr(cx_q, cy_q);
			end
			S_PK_WR: begin
				mem_we    = 1'b1;
				mem_waddr = tccs_pkg::cell_addr(cx_q, cy_q);
				mem_wdata = '{mask: tccs_pkg::TILES'(1) << tile_q, coll: 1'b1, pend: 1'b1};
			end
			S_P_EV: begin
				mem_we    = rd.pend;
				mem_wdata = '{mask: rd.mask, coll: rd.coll, pend: 1'b0};
			end
			S_N_CHK: begin
				mem_raddr = tccs_pkg::cell_addr(nx, ny);
			end
			S_N_EV: begin
				mem_we    = !rd.coll && (nm != rd.mask);
				mem_waddr = tccs_pkg::cell_addr(nx, ny);
				mem_wdata = '{mask: nm, coll: 1'b0, pend: 1'b1};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// divider requests: cell choice, then tile choice
	assign div_start = ((state_q == S_S1_END) && (count_q != '0)) ||
		((state_q == S_PK_EV) && (rd_pop != '0));
	assign div_dvd   = (state_q == S_S1_END) ? cpick_q : tpick_q;
	assign div_dsr   = (state_q == S_S1_END) ? count_q : tccs_pkg::CNT_W'(rd_pop);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= tccs_pkg::SIZE_W'(8);
			height_q   <= tccs_pkg::SIZE_W'(8);
			rules_q[0] <= tccs_pkg::RULE_W'(15153713);
			rules_q[1] <= tccs_pkg::RULE_W'(23799497);
			rules_q[2] <= tccs_pkg::RULE_W'(4092803);
			rules_q[3] <= tccs_pkg::RULE_W'(27454277);
		end else if (cfg_we) begin
			case (cfg_index)
				tccs_pkg::REG_WIDTH:  width_q    <= cfg_data[tccs_pkg::SIZE_W-1:0];
				tccs_pkg::REG_HEIGHT: height_q   <= cfg_data[tccs_pkg::SIZE_W-1:0];
				tccs_pkg::REG_NORTH:  rules_q[0] <= cfg_data;
				tccs_pkg::REG_EAST:   rules_q[1] <= cfg_data;
				tccs_pkg::REG_SOUTH:  rules_q[2] <= cfg_data;
				tccs_pkg::REG_WEST:   rules_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_addr_q <= '0;
			clr_out_q  <= 1'b0;
			again_q    <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == tccs_pkg::ADDR_W'(tccs_pkg::CELLS - 1)) begin
						state_q <= clr_out_q ? S_FIN : S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						cpick_q <= cell_pick;
						tpick_q <= tile_pick;
						best_q  <= tccs_pkg::POP_W'(tccs_pkg::TILES + 1);
						count_q <= '0;
						x_q     <= '0;
						y_q     <= '0;
						state_q <= S_S1_RD;
					end
				end
				S_S1_RD: begin
					state_q <= S_S1_EV;
				end
				S_S1_EV: begin
					if (!rd.coll) begin
						if (rd_pop < best_q) begin
							best_q  <= rd_pop;
							count_q <= tccs_pkg::CNT_W'(1);
						end else if (rd_pop == best_q) begin
							count_q <= count_q + 1'b1;
						end
					end
					x_q     <= x_nxt;
					y_q     <= y_nxt;
					state_q <= last_cell ? S_S1_END : S_S1_RD;
				end
				S_S1_END: begin
					if (count_q == '0) begin
						status_q   <= tccs_pkg::ST_DONE;
						cx_q       <= '0;
						cy_q       <= '0;
						tile_q     <= '0;
						clr_addr_q <= '0;
						clr_out_q  <= 1'b1;
						state_q    <= S_CLR;
					end else begin
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						target_q <= div_rem;
						seen_q   <= '0;
						x_q      <= '0;
						y_q      <= '0;
						state_q  <= S_S2_RD;
					end
				end
				S_S2_RD: begin
					state_q <= S_S2_EV;
				end
				S_S2_EV: begin
					x_q     <= x_nxt;
					y_q     <= y_nxt;
					state_q <= S_S2_RD;
					if (!rd.coll && (rd_pop == best_q)) begin
						seen_q <= seen_q + 1'b1;
						if (seen_q == target_q) begin
							cx_q    <= x_q;
							cy_q    <= y_q;
							state_q <= S_PK_RD;
						end
					end
				end
				S_PK_RD: begin
					state_q <= S_PK_EV;
				end
				S_PK_EV: begin
					cmask_q <= rd.mask;
					if (rd_pop == '0) begin
						tile_q  <= '0;
						state_q <= S_PK_WR;
					end else begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_done) begin
						tile_q  <= tccs_pkg::kth_tile(cmask_q,
							div_rem[tccs_pkg::POP_W-1:0]);
						state_q <= S_PK_WR;
					end
				end
				S_PK_WR: begin
					status_q <= tccs_pkg::ST_OK;
					x_q      <= '0;
					y_q      <= '0;
					again_q  <= 1'b0;
					state_q  <= S_P_RD;
				end
				S_P_RD: begin
					state_q <= S_P_EV;
				end
				S_P_EV: begin
					if (rd.pend) begin
						cmask_q <= rd.mask;
						again_q <= 1'b1;
						dir_q   <= tccs_pkg::DIR_N;
						state_q <= S_N_CHK;
					end else if (last_cell) begin
						x_q     <= '0;
						y_q     <= '0;
						again_q <= 1'b0;
						state_q <= again_q ? S_P_RD : S_FIN;
					end else begin
						x_q     <= x_nxt;
						y_q     <= y_nxt;
						state_q <= S_P_RD;
					end
				end
				S_N_CHK: begin
					if (n_ok) begin
						state_q <= S_N_EV;
					end else if (dir_q != tccs_pkg::DIR_W) begin
						dir_q <= dir_q + 1'b1;
					end else if (last_cell) begin
						x_q     <= '0;
						y_q     <= '0;
						again_q <= 1'b0;
						state_q <= S_P_RD;
					end else begin
						x_q     <= x_nxt;
						y_q     <= y_nxt;
						state_q <= S_P_RD;
					end
				end
				S_N_EV: begin
					if (!rd.coll && (nm == '0) && (rd.mask != '0)) begin
						status_q   <= tccs_pkg::ST_CONFL;
						clr_addr_q <= '0;
						clr_out_q  <= 1'b1;
						state_q    <= S_CLR;
					end else if (dir_q != tccs_pkg::DIR_W) begin
						dir_q   <= dir_q + 1'b1;
						state_q <= S_N_CHK;
					end else if (last_cell) begin
						x_q     <= '0;
						y_q     <= '0;
						again_q <= 1'b0;
						state_q <= S_P_RD;
					end else begin
						x_q     <= x_nxt;
						y_q     <= y_nxt;
						state_q <= S_P_RD;
					end
				end
				S_FIN: begin
					if (out_free) begin
						clr_out_q <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_FIN) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && out_free) begin
			rsp_status_q <= status_q;
			rsp_x_q      <= cx_q;
			rsp_y_q      <= cy_q;
			rsp_tile_q   <= tile_q;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign status    = rsp_status_q;
	assign cell_x    = rsp_x_q;
	assign cell_y    = rsp_y_q;
	assign tile      = rsp_tile_q;

endmodule

FILE: hdl/tccs_chk.sv
module tccs_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_stall,
	input logic                              rsp_valid,
	input logic                              rsp_stall,
	input logic [tccs_pkg::STATUS_W-1:0]     status,
	input logic [tccs_pkg::X_W-1:0]          cell_x,
	input logic [tccs_pkg::Y_W-1:0]          cell_y,
	input logic [tccs_pkg::TILE_W-1:0]       tile
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(tile))
		else $error("stalled response changed");

	// only defined status codes leave the block
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == tccs_pkg::ST_OK || status == tccs_pkg::ST_CONFL ||
		status == tccs_pkg::ST_DONE))
		else $error("undefined status");

	// a finished grid reports no cell
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == tccs_pkg::ST_DONE |->
		cell_x == '0 && cell_y == '0 && tile == '0)
		else $error("complete grid with nonzero cell");

	// chosen tile is in range
	a_tile: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> tile < tccs_pkg::TILE_W'(tccs_pkg::TILES))
		else $error("tile out of range");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

endmodule

bind tile_constraint_collapse_step tccs_chk u_tccs_chk (.*);

FILE: dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000000;
	localparam int SETTLE_CYCLES  = 1200;

	typedef struct {
		logic [tccs_pkg::STATUS_W-1:0] st;
		logic [tccs_pkg::X_W-1:0]      x;
		logic [tccs_pkg::Y_W-1:0]      y;
		logic [tccs_pkg::TILE_W-1:0]   tl;
	} step_result_t;

	// grid model plus store of expected step results
	class collapse_scoreboard;
		logic [tccs_pkg::TILES-1:0]  mask [tccs_pkg::CELLS];
		bit                          coll [tccs_pkg::CELLS];
		bit                          pend [tccs_pkg::CELLS];
		logic [tccs_pkg::SIZE_W-1:0] width_reg;
		logic [tccs_pkg::SIZE_W-1:0] height_reg;
		logic [tccs_pkg::RULE_W-1:0] rules [4];
		step_result_t                expected_steps [$];
		int                          errors;

		function new();
			width_reg  = 6'd8;
			height_reg = 6'd8;
			rules[tccs_pkg::DIR_N] = 25'd15153713;
			rules[tccs_pkg::DIR_E] = 25'd23799497;
			rules[tccs_pkg::DIR_S] = 25'd4092803;
			rules[tccs_pkg::DIR_W] = 25'd27454277;
			errors = 0;
			clear_grid();
		endfunction

		function void clear_grid();
			for (int i = 0; i < tccs_pkg::CELLS; i++) begin
				mask[i] = tccs_pkg::ALL_TILES;
				coll[i] = 1'b0;
				pend[i] = 1'b0;
			end
		endfunction

		function void write_reg(logic [tccs_pkg::CFG_IDX_W-1:0] idx,
				logic [tccs_pkg::RULE_W-1:0] data);
			case (idx)
				tccs_pkg::REG_WIDTH:  width_reg = data[tccs_pkg::SIZE_W-1:0];
				tccs_pkg::REG_HEIGHT: height_reg = data[tccs_pkg::SIZE_W-1:0];
				tccs_pkg::REG_NORTH:  rules[tccs_pkg::DIR_N] = data;
				tccs_pkg::REG_EAST:   rules[tccs_pkg::DIR_E] = data;
				tccs_pkg::REG_SOUTH:  rules[tccs_pkg::DIR_S] = data;
				tccs_pkg::REG_WEST:   rules[tccs_pkg::DIR_W] = data;
				default: ;
			endcase
		endfunction

		function int clamp_size(logic [tccs_pkg::SIZE_W-1:0] v, int mx);
			if (v == 0) return 1;
			if (int'(v) > mx) return mx;
			return int'(v);
		endfunction

		function logic [tccs_pkg::TILES-1:0] rule_union(int d,
				logic [tccs_pkg::TILES-1:0] m);
			logic [tccs_pkg::TILES-1:0] acc;
			acc = '0;
			for (int t = 0; t < tccs_pkg::TILES; t++) begin
				if (m[t]) acc |= rules[d][t*tccs_pkg::TILES +: tccs_pkg::TILES];
			end
			return acc;
		endfunction

		// arc consistency from the start cell, 1 on an emptied cell
		function bit spread_rules(int w, int h, int start);
			int dx [4] = '{0, 1, 0, -1};
			int dy [4] = '{-1, 0, 1, 0};
			bit again;
			int nx, ny, ni, idx;
			logic [tccs_pkg::TILES-1:0] nm;
			pend[start] = 1'b1;
			again = 1'b1;
			while (again) begin
				again = 1'b0;
				for (int y = 0; y < h; y++) begin
					for (int x = 0; x < w; x++) begin
						idx = y * tccs_pkg::MAX_W + x;
						if (!pend[idx]) continue;
						pend[idx] = 1'b0;
						again = 1'b1;
						for (int d = 0; d < 4; d++) begin
							nx = x + dx[d];
							ny = y + dy[d];
							if (nx < 0 || nx >= w || ny < 0 || ny >= h) continue;
							ni = ny * tccs_pkg::MAX_W + nx;
							if (coll[ni]) continue;
							nm = mask[ni] & rule_union(d, mask[idx]);
							if (nm != mask[ni]) begin
								mask[ni] = nm;
								if (nm == 0) return 1'b1;
								pend[ni] = 1'b1;
							end
						end
					end
				end
			end
			return 1'b0;
		endfunction

		function step_result_t collapse_one(logic [tccs_pkg::PICK_W-1:0] cp,
				logic [tccs_pkg::PICK_W-1:0] tp);
			step_result_t r;
			int w, h, best, count, target, seen, cx, cy, idx, n, k, tl, e;
			w = clamp_size(width_reg, tccs_pkg::MAX_W);
			h = clamp_size(height_reg, tccs_pkg::MAX_H);
			best = tccs_pkg::TILES + 1;
			count = 0;
			seen = 0;
			cx = 0;
			cy = 0;
			tl = 0;
			// lowest popcount among open cells
			for (int y = 0; y < h; y++) begin
				for (int x = 0; x < w; x++) begin
					if (coll[y*tccs_pkg::MAX_W + x]) continue;
					e = $countones(mask[y*tccs_pkg::MAX_W + x]);
					if (e < best) begin
						best = e;
						count = 1;
					end else if (e == best) begin
						count++;
					end
				end
			end
			if (count == 0) begin
				clear_grid();
				r = '{tccs_pkg::ST_DONE, '0, '0, '0};
				return r;
			end
			target = int'(cp) % count;
			for (int y = 0; y < h; y++) begin
				for (int x = 0; x < w; x++) begin
					if (coll[y*tccs_pkg::MAX_W + x]) continue;
					if ($countones(mask[y*tccs_pkg::MAX_W + x]) != best) continue;
					if (seen == target) begin
						cx = x;
						cy = y;
					end
					seen++;
				end
			end
			// pick the k-th possible tile
			idx = cy * tccs_pkg::MAX_W + cx;
			n = $countones(mask[idx]);
			if (n > 0) begin
				k = int'(tp) % n;
				for (int t = 0; t < tccs_pkg::TILES; t++) begin
					if (mask[idx][t]) begin
						if (k == 0) begin
							tl = t;
							break;
						end
						k--;
					end
				end
			end
			mask[idx] = tccs_pkg::TILES'(1) << tl;
			coll[idx] = 1'b1;
			r = '{tccs_pkg::ST_OK, tccs_pkg::X_W'(cx), tccs_pkg::Y_W'(cy),
				tccs_pkg::TILE_W'(tl)};
			if (spread_rules(w, h, idx)) begin
				clear_grid();
				r.st = tccs_pkg::ST_CONFL;
			end
			return r;
		endfunction

		function void note_request(logic [tccs_pkg::PICK_W-1:0] cp,
				logic [tccs_pkg::PICK_W-1:0] tp);
			expected_steps.insert(expected_steps.size(), collapse_one(cp, tp));
		endfunction

		function void check_result(step_result_t got);
			step_result_t want;
			if (expected_steps.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected response transaction st=%0d x=%0d y=%0d tile=%0d",
						got.st, got.x, got.y, got.tl);
				return;
			end
			want = expected_steps.pop_front();
			if (got.st !== want.st || got.x !== want.x || got.y !== want.y ||
					got.tl !== want.tl) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: expected st=%0d x=%0d y=%0d tile=%0d, ",
						"got st=%0d x=%0d y=%0d tile=%0d"},
						want.st, want.x, want.y, want.tl,
						got.st, got.x, got.y, got.tl);
			end
		endfunction

		function int outstanding();
			return expected_steps.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [tccs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tccs_pkg::RULE_W-1:0]    cfg_data;
	logic                           req_valid;
	logic                           req_stall;
	logic [tccs_pkg::PICK_W-1:0]    cell_pick;
	logic [tccs_pkg::PICK_W-1:0]    tile_pick;
	logic                           rsp_valid;
	logic                           rsp_stall;
	logic [tccs_pkg::STATUS_W-1:0]  status;
	logic [tccs_pkg::X_W-1:0]       cell_x;
	logic [tccs_pkg::Y_W-1:0]       cell_y;
	logic [tccs_pkg::TILE_W-1:0]    tile;

	collapse_scoreboard sb;
	int idle_mode;
	int quiet_cycles;

	tile_constraint_collapse_step dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall),
		.cell_pick(cell_pick), .tile_pick(tile_pick),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .cell_x(cell_x), .cell_y(cell_y), .tile(tile)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// response side stalls per idling mode
	always @(posedge clk) begin
		rsp_stall <= (idle_mode == 2 && $urandom_range(99) < 59) ||
			(idle_mode == 3 && $urandom_range(99) < 30);
	end

	// check responses and watch for a hung block
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				sb.check_result('{status, cell_x, cell_y, tile});
			end
			if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic set_reg(logic [tccs_pkg::CFG_IDX_W-1:0] idx,
			logic [tccs_pkg::RULE_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
	endtask

	task automatic apply_grid(logic [tccs_pkg::RULE_W-1:0] w, logic [tccs_pkg::RULE_W-1:0] h,
			logic [tccs_pkg::RULE_W-1:0] rn, logic [tccs_pkg::RULE_W-1:0] re,
			logic [tccs_pkg::RULE_W-1:0] rs, logic [tccs_pkg::RULE_W-1:0] rw);
		set_reg(tccs_pkg::REG_WIDTH, w);
		set_reg(tccs_pkg::REG_HEIGHT, h);
		set_reg(tccs_pkg::REG_NORTH, rn);
		set_reg(tccs_pkg::REG_EAST, re);
		set_reg(tccs_pkg::REG_SOUTH, rs);
		set_reg(tccs_pkg::REG_WEST, rw);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one request transaction, sender idles cycle by cycle per idling mode
	task automatic send_step(logic [tccs_pkg::PICK_W-1:0] cp,
			logic [tccs_pkg::PICK_W-1:0] tp);
		bit taken;
		while ((idle_mode == 1 && $urandom_range(99) < 59) ||
				(idle_mode == 3 && $urandom_range(99) < 30)) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		cell_pick <= cp;
		tile_pick <= tp;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !req_stall;
			if (taken) sb.note_request(cell_pick, tile_pick);
			@(posedge clk);
		end
	endtask

	// wait for every response, then let the block finish any clearing sweep
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [tccs_pkg::RULE_W-1:0] rand_rules();
		case ($urandom_range(3))
			0: return {tccs_pkg::RULE_W{1'b1}};
			1: return tccs_pkg::RULE_W'($urandom) | tccs_pkg::RULE_W'($urandom);
			2: return tccs_pkg::RULE_W'($urandom) | tccs_pkg::RULE_W'($urandom) |
				tccs_pkg::RULE_W'($urandom);
			default: return tccs_pkg::RULE_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [tccs_pkg::RULE_W-1:0] gw, gh;
		sb = new();
		idle_mode = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		cell_pick = '0;
		tile_pick = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset configuration, pick extremes
		send_step(16'h0000, 16'h0000);
		send_step(16'hFFFF, 16'hFFFF);
		send_step(16'h0000, 16'hFFFF);
		send_step(16'hFFFF, 16'h0000);
		send_step(16'hAAAA, 16'h5555);
		send_step(16'h5555, 16'hAAAA);
		drain();

		// single cell, free rules: collapse then grid complete
		apply_grid(1, 1, {tccs_pkg::RULE_W{1'b1}}, {tccs_pkg::RULE_W{1'b1}},
			{tccs_pkg::RULE_W{1'b1}}, {tccs_pkg::RULE_W{1'b1}});
		repeat (4) send_step(tccs_pkg::PICK_W'($urandom), tccs_pkg::PICK_W'($urandom));
		drain();

		// no tile allowed anywhere: contradiction on the first step
		apply_grid(2, 2, '0, '0, '0, '0);
		repeat (3) send_step(tccs_pkg::PICK_W'($urandom), tccs_pkg::PICK_W'($urandom));
		drain();

		// zero sizes clamp up to one, oversize clamps down to the maximum
		apply_grid(0, 0, 25'd15153713, 25'd23799497, 25'd4092803, 25'd27454277);
		repeat (3) send_step(tccs_pkg::PICK_W'($urandom), tccs_pkg::PICK_W'($urandom));
		drain();
		apply_grid(63, 1, {tccs_pkg::RULE_W{1'b1}}, {tccs_pkg::RULE_W{1'b1}},
			{tccs_pkg::RULE_W{1'b1}}, {tccs_pkg::RULE_W{1'b1}});
		repeat (2) send_step(16'hFFFF, 16'hFFFF);
		drain();
		apply_grid(32, 32, 25'd15153713, 25'd23799497, 25'd4092803, 25'd27454277);
		repeat (2) send_step(tccs_pkg::PICK_W'($urandom), tccs_pkg::PICK_W'($urandom));
		drain();

		// random phases, one per idling mode, several grid settings each
		for (int m = 0; m < 4; m++) begin
			idle_mode = m;
			for (int s = 0; s < 5; s++) begin
				gw = tccs_pkg::RULE_W'($urandom_range(1, 5));
				gh = tccs_pkg::RULE_W'($urandom_range(1, 5));
				if ($urandom_range(9) == 0) gw = tccs_pkg::RULE_W'($urandom_range(33, 63));
				if ($urandom_range(9) == 0) gw = 0;
				if ($urandom_range(9) == 0) gh = 0;
				apply_grid(gw, gh, rand_rules(), rand_rules(), rand_rules(), rand_rules());
				repeat (6) send_step(tccs_pkg::PICK_W'($urandom),
					tccs_pkg::PICK_W'($urandom));
				drain();
			end
		end

		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/tccs_pkg.sv
hdl/tccs_mem.sv
hdl/tccs_div.sv
hdl/tile_constraint_collapse_step.sv
hdl/tccs_chk.sv
dv/tb_top.sv
